// File: hw/rtl/sparse_2_4_int8_block_dot_assert.svh
// assertion macros for the sparse int8 block dot product
`ifndef SPARSE_2_4_INT8_BLOCK_DOT_ASSERT_SVH
`define SPARSE_2_4_INT8_BLOCK_DOT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define S24_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("s24dot assertion failed");

// next-cycle implication, disabled in reset
`define S24_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("s24dot assertion failed");

`endif

// File: hw/rtl/s24dot_pkg.sv
// shared types, constants and functions of the sparse int8 block dot product
`timescale 1ns / 1ps
package s24dot_pkg;

    localparam int NUM_GRP = 8;
    localparam int NUM_PROD = 16;
    localparam int NUM_PART = 4;
    localparam logic [31:0] FP32_QNAN = 32'h7fc0_0000;
    localparam logic [7:0] FP32_EXP_MAX = 8'hff;
    localparam logic [7:0] FP16_EXP_BIAS_ADJ = 8'd112;

    // one classified block handed from front to back
    typedef struct packed {
        logic signed [19:0] acc;
        logic [31:0]        scale;
        logic               last;
    } t_blk_job;

    // exact fp16 to fp32 conversion, subnormals normalized, nan quieted
    function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [9:0] mn;
        logic [3:0] sh;
        logic [7:0] e;
        logic [31:0] f;
        s = h[15];
        ex = h[14:10];
        man = h[9:0];
        sh = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) sh = 4'(10 - i);
        end
        mn = 10'(man << sh);
        e = 8'd113 - {4'd0, sh};
        if (ex == 5'd0) begin
            if (man == 10'd0) f = {s, 31'd0};
            else f = {s, e, mn, 13'd0};
        end else if (ex == 5'h1f) begin
            f = {s, FP32_EXP_MAX, man, 13'd0};
            if (man != 10'd0) f[22] = 1'b1;
        end else begin
            f = {s, {3'd0, ex} + FP16_EXP_BIAS_ADJ, man, 13'd0};
        end
        return f;
    endfunction

    // position of the leading one, 43-bit word
    function automatic logic [5:0] msb43(input logic [42:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 43; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    // position of the leading one, 28-bit word
    function automatic logic [4:0] msb28(input logic [27:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) p = 5'(i);
        end
        return p;
    endfunction

endpackage

// File: hw/rtl/s24dot_if.sv
// request and result channels of the sparse int8 block dot product
`timescale 1ns / 1ps
interface s24dot_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] weight_bytes_low;
    logic [63:0] weight_bytes_high;
    logic [63:0] position_bytes;
    logic [63:0] acts_0;
    logic [63:0] acts_1;
    logic [63:0] acts_2;
    logic [63:0] acts_3;
    logic [15:0] weight_scale;
    logic [15:0] act_scale;
    logic        last_block;

    modport source (output valid, weight_bytes_low, weight_bytes_high, position_bytes,
                    acts_0, acts_1, acts_2, acts_3, weight_scale, act_scale, last_block,
                    input ready);
    modport sink (input valid, weight_bytes_low, weight_bytes_high, position_bytes,
                  acts_0, acts_1, acts_2, acts_3, weight_scale, act_scale, last_block,
                  output ready);
endinterface

interface s24dot_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dot_bits;

    modport source (output valid, dot_bits, input ready);
    modport sink (input valid, dot_bits, output ready);
endinterface

// File: hw/rtl/s24dot_front.sv
// front end: sparse gather, int8 products, integer sum and exact scale product
`timescale 1ns / 1ps
module s24dot_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    s24dot_in_if.sink              i_blk,
    output s24dot_pkg::t_blk_job   o_job,
    output logic                   o_job_valid,
    input  logic                   i_job_ready
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SUM  = 4'b0010,
        F_SCL  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;

    logic signed [15:0] r_prod [s24dot_pkg::NUM_PROD];
    logic signed [15:0] n_prod [s24dot_pkg::NUM_PROD];
    logic signed [17:0] r_part [s24dot_pkg::NUM_PART];
    logic [15:0]        r_wscale, r_ascale;
    logic [31:0]        r_w32, r_a32;
    logic               r_last;
    s24dot_pkg::t_blk_job r_job;

    logic [255:0] acts_all;
    logic [127:0] wts_all;
    logic [31:0]  scale_prod;
    logic signed [19:0] acc_sum;

    assign acts_all = {i_blk.acts_3, i_blk.acts_2, i_blk.acts_1, i_blk.acts_0};
    assign wts_all = {i_blk.weight_bytes_high, i_blk.weight_bytes_low};

    // gather the two kept activations of each group of four
    always_comb begin
        logic [7:0] pb;
        logic [4:0] a1, a2;
        for (int g = 0; g < s24dot_pkg::NUM_GRP; g++) begin
            pb = i_blk.position_bytes[8*g +: 8];
            a1 = {3'(g), pb[5:4]};
            a2 = {3'(g), pb[1:0]};
            n_prod[2*g] = $signed(wts_all[16*g +: 8]) * $signed(acts_all[{a1, 3'd0} +: 8]);
            n_prod[2*g+1] = $signed(wts_all[16*g+8 +: 8])
                          * $signed(acts_all[{a2, 3'd0} +: 8]);
        end
    end

    // exact fp32 product of two converted fp16 scales
    always_comb begin
        logic sgn, nan_a, nan_b, inf_a, inf_b, zro_a, zro_b;
        logic [21:0] mp;
        logic [8:0]  ex;
        sgn = r_w32[31] ^ r_a32[31];
        nan_a = (r_w32[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_w32[22:0] != 23'd0);
        nan_b = (r_a32[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_a32[22:0] != 23'd0);
        inf_a = (r_w32[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_w32[22:0] == 23'd0);
        inf_b = (r_a32[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_a32[22:0] == 23'd0);
        zro_a = (r_w32[30:0] == 31'd0);
        zro_b = (r_a32[30:0] == 31'd0);
        mp = {1'b1, r_w32[22:13]} * {1'b1, r_a32[22:13]};
        ex = {1'b0, r_w32[30:23]} + {1'b0, r_a32[30:23]} - 9'd127;
        if (nan_a || nan_b || (inf_a && zro_b) || (zro_a && inf_b)) begin
            scale_prod = s24dot_pkg::FP32_QNAN;
        end else if (inf_a || inf_b) begin
            scale_prod = {sgn, s24dot_pkg::FP32_EXP_MAX, 23'd0};
        end else if (zro_a || zro_b) begin
            scale_prod = {sgn, 31'd0};
        end else if (mp[21]) begin
            scale_prod = {sgn, ex[7:0] + 8'd1, mp[20:0], 2'd0};
        end else begin
            scale_prod = {sgn, ex[7:0], mp[19:0], 3'd0};
        end
    end

    assign acc_sum = 20'(r_part[0]) + 20'(r_part[1]) + 20'(r_part[2]) + 20'(r_part[3]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_blk.valid) n_state = F_SUM;
            F_SUM:  n_state = F_SCL;
            F_SCL:  n_state = F_PUSH;
            F_PUSH: if (i_job_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_blk.valid) begin
            r_prod <= n_prod;
            r_wscale <= i_blk.weight_scale;
            r_ascale <= i_blk.act_scale;
            r_last <= i_blk.last_block;
        end
        if (r_state == F_SUM) begin
            for (int j = 0; j < s24dot_pkg::NUM_PART; j++) begin
                r_part[j] <= 18'(r_prod[4*j]) + 18'(r_prod[4*j+1])
                           + 18'(r_prod[4*j+2]) + 18'(r_prod[4*j+3]);
            end
            r_w32 <= s24dot_pkg::fp16_to_fp32(r_wscale);
            r_a32 <= s24dot_pkg::fp16_to_fp32(r_ascale);
        end
        if (r_state == F_SCL) begin
            r_job.acc <= acc_sum;
            r_job.scale <= scale_prod;
            r_job.last <= r_last;
        end
    end

    assign i_blk.ready = (r_state == F_IDLE);
    assign o_job = r_job;
    assign o_job_valid = (r_state == F_PUSH);

endmodule

// File: hw/rtl/s24dot_fifo.sv
// two-entry queue of classified blocks between front and back
`timescale 1ns / 1ps
module s24dot_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  s24dot_pkg::t_blk_job i_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    output s24dot_pkg::t_blk_job o_data,
    output logic                 o_valid,
    input  logic                 i_ready
);

    s24dot_pkg::t_blk_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

endmodule

// File: hw/rtl/s24dot_back.sv
// back end: fp32 scale multiply and running fp32 accumulation
`timescale 1ns / 1ps
module s24dot_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  s24dot_pkg::t_blk_job i_job,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    s24dot_out_if.source         o_res
);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_MUL  = 7'b0000010,
        B_NRM  = 7'b0000100,
        B_RND  = 7'b0001000,
        B_ALN  = 7'b0010000,
        B_ADD  = 7'b0100000,
        B_FIN  = 7'b1000000
    } t_bstate;

    typedef enum logic [1:0] {
        PC_FIN, PC_ZERO, PC_INF, PC_NAN
    } t_pcls;

    t_bstate r_state, n_state;
    s24dot_pkg::t_blk_job r_job;
    t_pcls       r_pcls;
    logic        r_psgn;
    logic [42:0] r_pm, r_nm;
    logic [9:0]  r_ne;
    logic [31:0] r_prod, r_sum;
    logic        r_spec, r_sub, r_rsgn;
    logic [31:0] r_spec_val;
    logic [7:0]  r_be;
    logic [26:0] r_ma, r_ms;
    logic [27:0] r_res;
    logic        r_out_valid;
    logic [31:0] r_out_bits;

    logic        out_free;
    logic [31:0] prod_bits, sum_bits;

    assign out_free = !r_out_valid || o_res.ready;

    // round the normalized product to fp32
    always_comb begin
        logic [23:0] sig;
        logic        rnd;
        sig = r_nm[42:19];
        rnd = r_nm[18] && ((|r_nm[17:0]) || sig[0]);
        unique case (r_pcls)
            PC_NAN:  prod_bits = s24dot_pkg::FP32_QNAN;
            PC_INF:  prod_bits = {r_psgn, s24dot_pkg::FP32_EXP_MAX, 23'd0};
            PC_ZERO: prod_bits = {r_psgn, 31'd0};
            default: prod_bits = {r_psgn, {r_ne[7:0], sig[22:0]} + {30'd0, rnd}};
        endcase
    end

    // normalize and round the sum
    always_comb begin
        logic [4:0]  k, sh;
        logic [8:0]  e;
        logic [26:0] rr;
        logic        rnd;
        k = s24dot_pkg::msb28(r_res);
        sh = 5'd26 - k;
        e = {1'b0, r_be};
        rr = r_res[26:0];
        if (k == 5'd27) begin
            rr = {r_res[27:2], r_res[1] | r_res[0]};
            e = {1'b0, r_be} + 9'd1;
        end else begin
            if (r_be <= {3'd0, sh}) begin
                sh = 5'(r_be - 8'd1);
                e = 9'd0;
            end else begin
                e = {1'b0, r_be} - {4'd0, sh};
            end
            rr = r_res[26:0] << sh;
        end
        rnd = rr[2] && ((|rr[1:0]) || rr[3]);
        if (r_spec) begin
            sum_bits = r_spec_val;
        end else if (r_res == 28'd0) begin
            sum_bits = 32'd0;
        end else if (e >= 9'd255) begin
            sum_bits = {r_rsgn, s24dot_pkg::FP32_EXP_MAX, 23'd0};
        end else begin
            sum_bits = {r_rsgn, {e[7:0], rr[25:3]} + {30'd0, rnd}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_job_valid) n_state = B_MUL;
            B_MUL:  n_state = B_NRM;
            B_NRM:  n_state = B_RND;
            B_RND:  n_state = B_ALN;
            B_ALN:  n_state = B_ADD;
            B_ADD:  n_state = B_FIN;
            B_FIN:  if (!r_job.last || out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_sum <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // hold until taken, reload when the last block finishes
            r_out_valid <= (r_out_valid && !o_res.ready)
                        || (r_state == B_FIN && r_job.last && out_free);
            if (r_state == B_FIN) begin
                if (!r_job.last) begin
                    r_sum <= sum_bits;
                end else if (out_free) begin
                    r_sum <= 32'd0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        logic [18:0] mag;
        logic        sc_nan, sc_inf, sc_zero, acc0;
        logic [5:0]  k;
        logic        nan_a, nan_b, inf_a, inf_b, zro_a, zro_b, swp;
        logic [31:0] big, sml;
        logic [7:0]  eb, es, d;
        logic [53:0] wide;
        mag = r_job.acc[19] ? 19'(-r_job.acc) : r_job.acc[18:0];
        sc_nan = (r_job.scale[30:23] == s24dot_pkg::FP32_EXP_MAX)
              && (r_job.scale[22:0] != 23'd0);
        sc_inf = (r_job.scale[30:23] == s24dot_pkg::FP32_EXP_MAX)
              && (r_job.scale[22:0] == 23'd0);
        sc_zero = (r_job.scale[30:23] == 8'd0);
        acc0 = (r_job.acc == 20'sd0);
        k = s24dot_pkg::msb43(r_pm);
        nan_a = (r_sum[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_sum[22:0] != 23'd0);
        nan_b = (r_prod[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_prod[22:0] != 23'd0);
        inf_a = (r_sum[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_sum[22:0] == 23'd0);
        inf_b = (r_prod[30:23] == s24dot_pkg::FP32_EXP_MAX) && (r_prod[22:0] == 23'd0);
        zro_a = (r_sum[30:0] == 31'd0);
        zro_b = (r_prod[30:0] == 31'd0);
        swp = (r_sum[30:0] < r_prod[30:0]);
        big = swp ? r_prod : r_sum;
        sml = swp ? r_sum : r_prod;
        eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d = eb - es;
        if (d > 8'd27) d = 8'd27;
        wide = {sml[30:23] != 8'd0, sml[22:0], 3'd0, 27'd0} >> d;

        if (r_state == B_IDLE && i_job_valid) r_job <= i_job;
        if (r_state == B_MUL) begin
            r_pm <= mag * {1'b1, r_job.scale[22:0]};
            r_psgn <= r_job.acc[19] ^ r_job.scale[31];
            if (sc_nan || (sc_inf && acc0)) r_pcls <= PC_NAN;
            else if (sc_inf) r_pcls <= PC_INF;
            else if (sc_zero || acc0) r_pcls <= PC_ZERO;
            else r_pcls <= PC_FIN;
        end
        if (r_state == B_NRM) begin
            r_nm <= r_pm << (6'd42 - k);
            r_ne <= {4'd0, k} + {2'd0, r_job.scale[30:23]} - 10'd23;
        end
        if (r_state == B_RND) r_prod <= prod_bits;
        if (r_state == B_ALN) begin
            if (nan_a || nan_b || (inf_a && inf_b && (r_sum[31] != r_prod[31]))) begin
                r_spec <= 1'b1;
                r_spec_val <= s24dot_pkg::FP32_QNAN;
            end else if (inf_a || zro_b) begin
                r_spec <= 1'b1;
                r_spec_val <= (zro_a && zro_b) ? {r_sum[31] & r_prod[31], 31'd0} : r_sum;
            end else if (inf_b || zro_a) begin
                r_spec <= 1'b1;
                r_spec_val <= r_prod;
            end else begin
                r_spec <= 1'b0;
            end
            r_ma <= {big[30:23] != 8'd0, big[22:0], 3'd0};
            r_ms <= {wide[53:28], wide[27] | (|wide[26:0])};
            r_sub <= big[31] ^ sml[31];
            r_rsgn <= big[31];
            r_be <= eb;
        end
        if (r_state == B_ADD) begin
            r_res <= r_sub ? ({1'b0, r_ma} - {1'b0, r_ms}) : ({1'b0, r_ma} + {1'b0, r_ms});
        end
        if (r_state == B_FIN && r_job.last && out_free) r_out_bits <= sum_bits;
    end

    assign o_job_ready = (r_state == B_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.dot_bits = r_out_bits;

endmodule

// File: hw/rtl/sparse_2_4_int8_block_dot.sv
// top level of the two-of-four sparse int8 block dot product
`timescale 1ns / 1ps
// each request is one 32-element block: 16 kept int8 weights, their 2-of-4
// positions, 32 int8 activations and two fp16 scales. the front end takes a
// request (gather and multiply, partial sums, scale product, hand-off) into a
// two-deep queue and accepts the next only once it is idle again. the back end
// turns each block into an fp32 term (multiply, normalize, round) and adds it
// to the running fp32 sum (align, add, normalize and round); this running-sum
// sequencer takes one block at a time and sets the sustained rate. a request
// with last_block set returns the sum as dot_bits through an output register
// and clears it; nan results come out as 0x7fc00000
module sparse_2_4_int8_block_dot (
    input  logic         i_clk,
    input  logic         i_rst_n,
    s24dot_in_if.sink    i_blk,
    s24dot_out_if.source o_res
);

    // front to queue
    s24dot_pkg::t_blk_job fe_job;
    logic                 fe_valid, fe_ready;
    // queue to back
    s24dot_pkg::t_blk_job be_job;
    logic                 be_valid, be_ready;

    s24dot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (i_blk),
        .o_job       (fe_job),
        .o_job_valid (fe_valid),
        .i_job_ready (fe_ready)
    );

    // decouples the integer front from the fp back
    s24dot_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (fe_job),
        .i_valid (fe_valid),
        .o_ready (fe_ready),
        .o_data  (be_job),
        .o_valid (be_valid),
        .i_ready (be_ready)
    );

    s24dot_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (be_job),
        .i_job_valid (be_valid),
        .o_job_ready (be_ready),
        .o_res       (o_res)
    );

endmodule

// File: hw/rtl/s24dot_chk.sv
// port checker of the sparse int8 block dot product and its bind
`timescale 1ns / 1ps
`include "sparse_2_4_int8_block_dot_assert.svh"
module s24dot_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_dot_bits
);

    // a nan on the output is always the canonical quiet one
    logic dot_ok;
    assign dot_ok = (i_dot_bits[30:0] <= 31'h7f80_0000)
                 || (i_dot_bits == s24dot_pkg::FP32_QNAN);

    `S24_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `S24_ASSERT_NXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_dot_bits))
    `S24_ASSERT_IMP(a_nan_canon, i_out_valid, dot_ok)
    `S24_ASSERT_IMP(a_rst_out, $past(!i_rst_n), !i_out_valid)
    `S24_ASSERT_IMP(a_rst_ready, $past(!i_rst_n), i_in_ready || !i_in_valid)

endmodule

bind sparse_2_4_int8_block_dot s24dot_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_blk.valid),
    .i_in_ready  (i_blk.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_dot_bits  (o_res.dot_bits)
);
